@@ sv/mscg_pkg.sv @@
// ============================================================================
// Multi-stop colour gradient package
// Shared types, codes and constants for the gradient controller and datapath.
// ============================================================================
package mscg_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_STOPS_DEF     = 16;
    localparam int POSITION_BITS_DEF = 16;

    // Fixed field widths.
    localparam int POS_FIELD_W = 16;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 4 * CHAN_W;
    localparam int STATUS_W    = 2;

    // Blend factor is unsigned Q1.16.
    localparam int FRAC_BITS = 16;
    localparam int DCNT_W    = $clog2(FRAC_BITS);

    // Item opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIRST,
        S_READ,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_SUM
    } t_state;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_CUR,
        SEL_BLEND
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                write;
        logic                rd;
        logic                take;
        logic                inc;
        logic                div_init;
        logic                div_step;
        logic                mul;
        logic                emit;
        t_out_sel            sel;
        logic [STATUS_W-1:0] code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic full;
        logic empty;
        logic below_eps;
        logic last;
        logic above;
        logic div_last;
    } t_sts;

endpackage

@@ sv/mscg_ctrl.sv @@
// ============================================================================
// Gradient controller
// Sequences inserts, the stop scan, the division and the blend.
// ============================================================================
module mscg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  mscg_pkg::t_sts  i_sts,
    output mscg_pkg::t_cmd  o_cmd
);
    import mscg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_query || i_sts.empty) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_sts.below_eps || i_sts.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.above) begin
                    n_state = S_DIV;
                end else if (i_sts.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = SEL_ZERO;
        o_cmd.code = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_DECODE: begin
                if (!i_sts.is_query) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.write = !i_sts.full;
                    o_cmd.code  = i_sts.full ? ST_FULL : ST_OK;
                end else if (i_sts.empty) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_EMPTY;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            S_FIRST: begin
                o_cmd.take = 1'b1;
                if (i_sts.below_eps || i_sts.last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_CUR;
                end else begin
                    o_cmd.inc = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_CHECK: begin
                if (i_sts.above) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.take = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = SEL_CUR;
                    end else begin
                        o_cmd.inc = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_SUM: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = SEL_BLEND;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ sv/mscg_dp.sv @@
// ============================================================================
// Gradient datapath
// Stop table, scan registers, restoring divider, blend and result registers.
// ============================================================================
module mscg_dp #(
    parameter int MAX_STOPS     = mscg_pkg::MAX_STOPS_DEF,
    parameter int POSITION_BITS = mscg_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mscg_pkg::t_cmd                      i_cmd,
    output mscg_pkg::t_sts                      o_sts,
    input  logic                                i_opcode,
    input  logic [mscg_pkg::POS_FIELD_W-1:0]    i_position,
    input  logic [mscg_pkg::CHAN_W-1:0]         i_in_red,
    input  logic [mscg_pkg::CHAN_W-1:0]         i_in_green,
    input  logic [mscg_pkg::CHAN_W-1:0]         i_in_blue,
    input  logic [mscg_pkg::CHAN_W-1:0]         i_in_alpha,
    output logic                                o_valid,
    output logic [mscg_pkg::CHAN_W-1:0]         o_out_red,
    output logic [mscg_pkg::CHAN_W-1:0]         o_out_green,
    output logic [mscg_pkg::CHAN_W-1:0]         o_out_blue,
    output logic [mscg_pkg::CHAN_W-1:0]         o_out_alpha,
    output logic [mscg_pkg::STATUS_W-1:0]       o_status
);
    import mscg_pkg::*;

    // Stored positions keep only the bits that the position field can carry.
    localparam int PW       = (POSITION_BITS < POS_FIELD_W) ? POSITION_BITS : POS_FIELD_W;
    localparam int SW       = PW + 1;
    localparam int EPS_CODE = ((1 << POSITION_BITS) + 5000) / 10000;
    localparam int CW       = $clog2(MAX_STOPS + 1);
    localparam int IW       = $clog2(MAX_STOPS);
    localparam int FW       = FRAC_BITS + 1;
    localparam int PROD_W   = CHAN_W + 1 + FW + 1;
    localparam int ROUND    = 1 << (FRAC_BITS - 1);

    // Stop table.
    logic [PW-1:0]      mem_pos [MAX_STOPS];
    logic [COLOR_W-1:0] mem_col [MAX_STOPS];

    logic               r_op;
    logic [PW-1:0]      r_pos;
    logic [COLOR_W-1:0] r_col;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_idx;
    logic [PW-1:0]      r_rd_pos;
    logic [COLOR_W-1:0] r_rd_col;
    logic [PW-1:0]      r_prev_pos;
    logic [COLOR_W-1:0] r_prev_col;

    // Divider.
    logic [PW-1:0]        r_rem;
    logic [PW-1:0]        r_ms;
    logic [FRAC_BITS-1:0] r_q;
    logic [DCNT_W-1:0]    r_dcnt;
    logic                 r_fzero;
    logic                 r_fclamp;

    logic signed [PROD_W-1:0] r_prod [4];

    logic               r_valid;
    logic [COLOR_W-1:0] r_out_col;
    logic [STATUS_W-1:0] r_out_st;

    logic signed [PW:0] off;
    logic signed [PW:0] span;
    logic [PW-1:0]      mo;
    logic [PW-1:0]      ms;
    logic [PW:0]        trial;
    logic [FW-1:0]      frac;
    logic [COLOR_W-1:0] blend_col;

    // Scan status.
    always_comb begin
        o_sts.is_query  = (r_op == OP_QUERY);
        o_sts.full      = (r_count >= CW'(MAX_STOPS));
        o_sts.empty     = (r_count == '0);
        o_sts.below_eps = ({1'b0, r_pos} < ({1'b0, r_rd_pos} + SW'(EPS_CODE)));
        o_sts.last      = ((CW'(r_idx) + CW'(1)) == r_count);
        o_sts.above     = (r_pos < r_rd_pos);
        o_sts.div_last  = (r_dcnt == DCNT_W'(FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_pos <= i_position[PW-1:0];
            r_col <= {i_in_red, i_in_green, i_in_blue, i_in_alpha};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.write) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.inc) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem_pos[r_count[IW-1:0]] <= r_pos;
            mem_col[r_count[IW-1:0]] <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_pos <= mem_pos[r_idx];
            r_rd_col <= mem_col[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_prev_pos <= r_rd_pos;
            r_prev_col <= r_rd_col;
        end
    end

    // Offset and span magnitudes, relative to the earlier stop.
    always_comb begin
        off   = $signed({1'b0, r_pos}) - $signed({1'b0, r_prev_pos});
        span  = $signed({1'b0, r_rd_pos}) - $signed({1'b0, r_prev_pos});
        mo    = off[PW] ? PW'(-off) : off[PW-1:0];
        ms    = span[PW] ? PW'(-span) : span[PW-1:0];
        trial = {r_rem, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem    <= mo;
            r_ms     <= ms;
            r_q      <= '0;
            r_dcnt   <= '0;
            r_fzero  <= (span == '0) || (mo == '0) || (off[PW] != span[PW]);
            r_fclamp <= (mo >= ms);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DCNT_W'(1);
            if (trial >= {1'b0, r_ms}) begin
                r_rem <= PW'(trial - {1'b0, r_ms});
                r_q   <= {r_q[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= trial[PW-1:0];
                r_q   <= {r_q[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_fzero) begin
            frac = '0;
        end else if (r_fclamp) begin
            frac = FW'(1) << FRAC_BITS;
        end else begin
            frac = {1'b0, r_q};
        end
    end

    // Each channel is c0 + round((c1 - c0) * frac / 2^16).
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= PROD_W'(
                    ($signed({1'b0, r_rd_col[k*CHAN_W +: CHAN_W]})
                     - $signed({1'b0, r_prev_col[k*CHAN_W +: CHAN_W]}))
                    * $signed({1'b0, frac}));
            end
        end
    end

    always_comb begin
        logic signed [PROD_W-1:0] rounded;
        logic signed [PROD_W-1:0] shifted;
        blend_col = '0;
        for (int k = 0; k < 4; k++) begin
            rounded = r_prod[k] + PROD_W'(ROUND);
            shifted = rounded >>> FRAC_BITS;
            blend_col[k*CHAN_W +: CHAN_W] =
                r_prev_col[k*CHAN_W +: CHAN_W] + shifted[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_st <= i_cmd.code;
            case (i_cmd.sel)
                SEL_ZERO:  r_out_col <= '0;
                SEL_CUR:   r_out_col <= r_rd_col;
                SEL_BLEND: r_out_col <= blend_col;
                default:   r_out_col <= '0;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_out_red   = r_out_col[4*CHAN_W-1 -: CHAN_W];
    assign o_out_green = r_out_col[3*CHAN_W-1 -: CHAN_W];
    assign o_out_blue  = r_out_col[2*CHAN_W-1 -: CHAN_W];
    assign o_out_alpha = r_out_col[CHAN_W-1 -: CHAN_W];
    assign o_status    = r_out_st;

endmodule

@@ sv/multi_stop_color_gradient_core.sv @@
// ============================================================================
// Multi-stop colour gradient core
// Holds a table of colour stops and returns the blended colour at a position.
// ============================================================================
// An item is taken when start is high and busy is low; each item gives exactly
// one result, shown on the o_out_* and o_status ports for a single cycle while
// o_valid is high. The receiver cannot hold results off, so capture them on
// that cycle. An insert, or a query on an empty table, is answered from the
// decode state. A query first reads and checks the first stop, then reads and
// checks each further stop of the table in turn; a query that lands between
// two stops then runs the blend-factor division, which forms one quotient bit
// for each of the sixteen fraction bits, and then the multiply and the sum of
// the blend. Busy falls as the result appears, so the next item can be
// accepted at the edge that takes the result. Query time grows with the table
// index of the upper stop of the pair, as the single-port stop table is read
// one entry at a time, and with the one-bit-per-cycle restoring divider.
// ============================================================================
module multi_stop_color_gradient_core #(
    parameter int MAX_STOPS     = mscg_pkg::MAX_STOPS_DEF,
    parameter int POSITION_BITS = mscg_pkg::POSITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_opcode,
    input  logic [mscg_pkg::POS_FIELD_W-1:0] i_position,
    input  logic [mscg_pkg::CHAN_W-1:0]      i_in_red,
    input  logic [mscg_pkg::CHAN_W-1:0]      i_in_green,
    input  logic [mscg_pkg::CHAN_W-1:0]      i_in_blue,
    input  logic [mscg_pkg::CHAN_W-1:0]      i_in_alpha,
    output logic                             o_valid,
    output logic [mscg_pkg::CHAN_W-1:0]      o_out_red,
    output logic [mscg_pkg::CHAN_W-1:0]      o_out_green,
    output logic [mscg_pkg::CHAN_W-1:0]      o_out_blue,
    output logic [mscg_pkg::CHAN_W-1:0]      o_out_alpha,
    output logic [mscg_pkg::STATUS_W-1:0]    o_status
);
    import mscg_pkg::*;

    // The controller and datapath talk only through these two structs.
    t_cmd cmd;
    t_sts sts;

    // The controller walks the table one stop at a time. The first stop is
    // checked against the epsilon; after that the scan stops at the first
    // entry lying above the query position, and the entry before it becomes
    // the lower end of the blend.
    mscg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath holds the stop table, the inputs of the current item, the
    // divider that forms the blend factor and the registered result.
    mscg_dp #(
        .MAX_STOPS     (MAX_STOPS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_status    (o_status)
    );

endmodule
